>>> rtl/core/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared definitions for the modular inverse block
// constants and sequencer state type used across the design
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

    // default operand width, 63 bits keeps the signed coefficient in 64 bits
    localparam int WIDTH_DEF = 63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_LIFT,
        ST_FIX,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/mie_div_unit.sv
// ----------------------------------------------------------------------------
// mie_div_unit: bit-serial divide with coefficient product
// restoring division one quotient bit per cycle, with q*c built by horner steps
// ----------------------------------------------------------------------------
`default_nettype none

module mie_div_unit
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [WIDTH-1:0] i_dividend,
    input  wire logic [WIDTH-1:0] i_divisor,
    input  wire logic [WIDTH:0]   i_coef,
    output logic                  o_done,
    output logic [WIDTH-1:0]      o_rem,
    output logic [WIDTH:0]        o_prod
);

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_dvd;
    logic [WIDTH-1:0] r_dvs;
    logic [WIDTH:0]   r_coef;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH:0]   r_prod;

    logic [WIDTH:0]   rem_sh;
    logic [WIDTH+1:0] diff;
    logic             qbit;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH:0]   n_prod;

    always_comb begin
        rem_sh = {r_rem, r_dvd[WIDTH-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
        qbit   = ~diff[WIDTH+1];
        n_rem  = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
        // product kept modulo 2^(WIDTH+1), true value stays small
        n_prod = {r_prod[WIDTH-1:0], 1'b0} + (qbit ? r_coef : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_coef <= i_coef;
            r_rem  <= '0;
            r_prod <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[WIDTH-2:0], 1'b0};
            r_rem  <= n_rem;
            r_prod <= n_prod;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> rtl/core/modular_inverse_ext_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by extended euclid
// returns value^-1 mod modulus and gcd(value, modulus), one result per item
// ----------------------------------------------------------------------------
// One transaction carries a value and a modulus; one result transaction comes
// back with the inverse and the gcd. The inverse is only meaningful when the
// gcd is one; otherwise it holds the lifted bezout coefficient. A zero modulus
// gives inverse zero and gcd equal to the value. Only one item is in work at a
// time: s_axis_tready is high only while the sequencer is idle. Each euclid
// round runs through one shared bit-serial divider, which also builds the
// quotient times coefficient product; the first round is the reduction of
// the value by the modulus, and for 63-bit operands the round count stays
// below about 93. The finished result waits in an output register, so the
// next item can be taken while it is not yet picked up.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_ext_euclid
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH], zero pad above
    input  wire logic [8*((2*WIDTH+7)/8)-1:0]         s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // inverse [WIDTH-1:0], common_divisor [2*WIDTH-1:WIDTH], zero pad above
    output logic [8*((2*WIDTH+7)/8)-1:0]              m_axis_tdata
);

    localparam int DATA_W = 8 * ((2 * WIDTH + 7) / 8);

    // sequencer
    t_state r_state;
    t_state n_state;

    // euclid pair and bezout coefficient pair (two's complement, WIDTH+1 bits)
    logic [WIDTH-1:0] r_mod;
    logic [WIDTH-1:0] r_rp;
    logic [WIDTH-1:0] r_rc;
    logic [WIDTH:0]   r_cp;
    logic [WIDTH:0]   r_cc;

    // result register
    logic             r_out_valid;
    logic [WIDTH-1:0] r_out_inv;
    logic [WIDTH-1:0] r_out_gcd;

    logic             in_hs;
    logic             div_start;
    logic             out_load;
    logic             div_done;
    logic [WIDTH-1:0] div_rem;
    logic [WIDTH:0]   div_prod;
    logic [WIDTH:0]   mod_ext;

    assign in_hs   = s_axis_tvalid & s_axis_tready;
    assign mod_ext = {1'b0, r_mod};

    // shared divide unit: quotient bits and q*c_cur product per round
    mie_div_unit #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rp),
        .i_divisor  (r_rc),
        .i_coef     (r_cc),
        .o_done     (div_done),
        .o_rem      (div_rem),
        .o_prod     (div_prod)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_hs) n_state = ST_CHECK;
            ST_CHECK: n_state = (r_rc == '0) ? ST_LIFT : ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_CHECK;
            ST_LIFT:  n_state = ST_FIX;
            ST_FIX:   n_state = ST_DONE;
            ST_DONE:  if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CHECK: div_start = (r_rc != '0);
            ST_DONE:  out_load = !r_out_valid || m_axis_tready;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath: the first round (value, modulus) with coefficients (1, 0)
    // does the reduction of the value by the modulus
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_hs) begin
                    r_rp  <= s_axis_tdata[WIDTH-1:0];
                    r_rc  <= s_axis_tdata[2*WIDTH-1:WIDTH];
                    r_mod <= s_axis_tdata[2*WIDTH-1:WIDTH];
                    r_cp  <= (WIDTH+1)'(1);
                    r_cc  <= '0;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    r_rp <= r_rc;
                    r_rc <= div_rem;
                    r_cp <= r_cc;
                    r_cc <= r_cp - div_prod;
                end
            end
            ST_LIFT: begin
                // zero modulus forces inverse zero, negative coefficient lifted
                if (r_mod == '0) begin
                    r_cp <= '0;
                end else if (r_cp[WIDTH]) begin
                    r_cp <= r_cp + mod_ext;
                end
            end
            ST_FIX: begin
                if (r_cp >= mod_ext && r_mod != '0) begin
                    r_cp <= r_cp - mod_ext;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_inv <= r_cp[WIDTH-1:0];
            r_out_gcd <= r_rp;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    // zero extension fills the pad bits
    assign m_axis_tdata  = DATA_W'({r_out_gcd, r_out_inv});

endmodule

`default_nettype wire

>>> rtl/core/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker: port-level checks for the modular inverse block
// watches the stream ports of the top level over time
// ----------------------------------------------------------------------------
`default_nettype none

module mie_checker
    import mie_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic [8*((2*WIDTH+7)/8)-1:0] s_axis_tdata,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [8*((2*WIDTH+7)/8)-1:0] m_axis_tdata
);

    logic in_hs;

    assign in_hs = s_axis_tvalid & s_axis_tready;

    // a stalled result holds valid and data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item at a time: busy right after a transaction is taken
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_hs |=> !s_axis_tready)
        else $error("ready right after input transaction");

    // ready only drops because a transaction was taken
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(in_hs))
        else $error("ready dropped without input transaction");

    // a result needs at least the check, lift and fix steps after its input
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(in_hs) && !$past(in_hs, 2))
        else $error("result appeared too soon after input");

    // pad bits of the result stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >> (2 * WIDTH)) == '0)
        else $error("nonzero pad bits in result");

    logic unused_in;
    assign unused_in = ^s_axis_tdata;

endmodule

bind modular_inverse_ext_euclid mie_checker #(
    .WIDTH (WIDTH)
) u_mie_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
